FILE: rtl/sbrs_pkg.sv
// Types and constants shared by the spread band reversion signal block.
// No dependencies.
package sbrs_pkg;
    typedef enum logic [1:0] {
        POS_FLAT  = 2'd0,
        POS_LONG  = 2'd1,
        POS_SHORT = 2'd2
    } t_pos;

    localparam logic [1:0] SIDE_HOLD = 2'd0;
    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_RATIO  = 2'd1;
    localparam logic [1:0] REG_BAND   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_SPREAD,
        ST_RDOLD,
        ST_OLDSQ,
        ST_NEWSQ,
        ST_UPD,
        ST_DSQ,
        ST_LHS,
        ST_NQ,
        ST_SSQ,
        ST_RN,
        ST_BB,
        ST_RHS,
        ST_DEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [127:0] a;
        logic [63:0]  b;
    } t_mul_req;
endpackage

FILE: rtl/sbrs_mul.sv
// Shared 128x64 unsigned multiplier, product kept to 128 bits; eight 32x32
// partial products, one per cycle. Depends on sbrs_pkg.
module sbrs_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sbrs_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [127:0]      o_prod
);
    import sbrs_pkg::*;

    logic [2:0]   r_step;
    logic         r_busy;
    logic [127:0] r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [31:0]  w_x;
    logic [31:0]  w_y;
    logic [63:0]  w_pp;
    logic [7:0]   w_shamt;
    logic [127:0] w_sh;

    always_comb begin
        w_x = r_a[{r_step[1:0], 5'd0} +: 32];
        w_y = r_step[2] ? r_b[63:32] : r_b[31:0];
        w_pp = {32'd0, w_x} * {32'd0, w_y};
        w_shamt = {1'b0, r_step[1:0], 5'd0} + {2'b0, r_step[2], 5'd0};
        w_sh = {64'd0, w_pp} << w_shamt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc  <= r_acc + w_sh;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;
endmodule

FILE: rtl/spread_band_reversion_signal.sv
// Top level of the spread band reversion signal block: sequencer, window ring
// and statistics. Depends on sbrs_pkg and sbrs_mul.
//
// Usage: one request on the input channel carries price_a and price_b. The
// block forms the hedged spread, updates a ring of the last N spreads with
// running sum and sum of squares, and returns one request on the output channel
// with side_a, side_b and warmed_up.
// Every product goes through one shared multiplier: a start, eight 32x32
// partial products, then done. While the window fills, three products are
// needed per item; once full, seven more products are needed for the band test.
// The input stall stays high from acceptance until the result has been taken,
// so the block takes no new item while one is still in flight.
// Reset clears window statistics, position and configuration registers to their defaults.
// A stalled output holds its result and the block takes no new item meanwhile.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module spread_band_reversion_signal #(
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_price_a,
    input  logic [31:0] i_price_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_side_a,
    output logic [1:0]  o_side_b,
    output logic        o_warmed_up,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import sbrs_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW = $clog2(MAX_WINDOW + 1);

    t_state        r_st, n_st;
    t_pos          r_pos;
    logic [6:0]    r_win;
    logic [23:0]   r_ratio;
    logic [15:0]   r_band;
    logic [31:0]   r_pa, r_pb;
    logic signed [31:0] r_s;
    logic signed [47:0] r_sum;
    logic [127:0]  r_sq;
    logic [NW-1:0] r_fill;
    logic [AW-1:0] r_slot;
    logic signed [31:0] r_mem [MAX_WINDOW];
    logic signed [31:0] r_rd;
    logic signed [63:0] r_d;
    logic [127:0]  r_lhs, r_t;
    logic          r_full;
    logic [1:0]    r_sa, r_sb;

    logic          w_start, w_done;
    t_mul_req      w_req;
    logic [127:0]  w_prod;
    logic [NW-1:0] w_n;
    logic [63:0]   w_sm, w_dm;
    logic [63:0]   w_om, w_nm;
    logic          w_full_nx;

    sbrs_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_req  (w_req),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    always_comb begin
        if (r_win < 7'd2)
            w_n = NW'(2);
        else if ({25'd0, r_win} > MAX_WINDOW)
            w_n = NW'(MAX_WINDOW);
        else
            w_n = NW'(r_win);
    end

    assign w_sm = r_sum[47] ? 64'(-r_sum) : 64'(r_sum);
    assign w_dm = r_d[63] ? -r_d : r_d;
    assign w_om = {32'd0, r_rd[31] ? 32'(-r_rd) : 32'(r_rd)};
    assign w_nm = {32'd0, r_s[31] ? 32'(-r_s) : 32'(r_s)};
    assign w_full_nx = (r_fill >= w_n - NW'(1));

    logic r_wait;
    always_comb begin
        w_start = 1'b0;
        w_req   = '0;
        n_st    = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_PROD;
            ST_PROD: begin
                w_req = '{a: {104'd0, r_ratio}, b: {32'd0, r_pb}};
                w_start = !r_wait;
                if (w_done) n_st = ST_SPREAD;
            end
            ST_SPREAD: n_st = ST_RDOLD;
            ST_RDOLD: n_st = ST_OLDSQ;
            ST_OLDSQ: begin
                w_req = '{a: {64'd0, w_om}, b: w_om};
                w_start = !r_wait;
                if (w_done) n_st = ST_NEWSQ;
            end
            ST_NEWSQ: begin
                w_req = '{a: {64'd0, w_nm}, b: w_nm};
                w_start = !r_wait;
                if (w_done) n_st = ST_UPD;
            end
            ST_UPD: n_st = w_full_nx ? ST_DSQ : ST_OUT;
            ST_DSQ: begin
                w_req = '{a: {64'd0, w_dm}, b: 64'(w_n - NW'(1))};
                w_start = !r_wait;
                if (w_done) n_st = ST_LHS;
            end
            ST_LHS: begin
                w_req = '{a: {64'd0, r_t[63:0]}, b: w_dm};
                w_start = !r_wait;
                if (w_done) n_st = ST_NQ;
            end
            ST_NQ: begin
                w_req = '{a: r_sq, b: 64'(w_n)};
                w_start = !r_wait;
                if (w_done) n_st = ST_SSQ;
            end
            ST_SSQ: begin
                w_req = '{a: {64'd0, w_sm}, b: w_sm};
                w_start = !r_wait;
                if (w_done) n_st = ST_RN;
            end
            ST_RN: begin
                w_req = '{a: r_t, b: 64'(w_n)};
                w_start = !r_wait;
                if (w_done) n_st = ST_BB;
            end
            ST_BB: begin
                w_req = '{a: r_t, b: {48'd0, r_band}};
                w_start = !r_wait;
                if (w_done) n_st = ST_RHS;
            end
            ST_RHS: begin
                w_req = '{a: r_t, b: {48'd0, r_band}};
                w_start = !r_wait;
                if (w_done) n_st = ST_DEC;
            end
            ST_DEC: n_st = ST_OUT;
            ST_OUT: if (!i_stall) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wait <= 1'b0;
        else if (w_done || n_st != r_st) r_wait <= 1'b0;
        else if (w_start) r_wait <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_RDOLD && r_fill >= w_n) r_rd <= r_mem[r_slot];
        if (r_st == ST_UPD) r_mem[r_slot] <= r_s;
    end

    logic signed [41:0] w_diff;
    assign w_diff = $signed({10'b0, r_pa}) - $signed({2'b0, w_prod[55:16]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FLAT;
            r_win   <= 7'd20;
            r_ratio <= 24'd65536;
            r_band  <= 16'd8192;
            r_sum   <= '0;
            r_sq    <= '0;
            r_fill  <= '0;
            r_slot  <= '0;
            r_full  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW: begin
                        r_win  <= i_cfg_data[6:0];
                        r_sum  <= '0;
                        r_sq   <= '0;
                        r_fill <= '0;
                        r_slot <= '0;
                    end
                    REG_RATIO: r_ratio <= i_cfg_data;
                    REG_BAND:  r_band  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_pa <= i_price_a;
                    r_pb <= i_price_b;
                end
                ST_SPREAD: begin
                    if (w_diff > 42'sd2147483647)       r_s <= 32'h7fffffff;
                    else if (w_diff < -42'sd2147483648) r_s <= 32'h80000000;
                    else                                r_s <= w_diff[31:0];
                    if ({1'b0, r_slot} >= w_n) r_slot <= '0;
                end
                ST_OLDSQ: if (w_done && r_fill >= w_n) begin
                    r_sq  <= r_sq - w_prod;
                    r_sum <= r_sum - 48'(r_rd);
                end
                ST_NEWSQ: if (w_done) begin
                    r_sq  <= r_sq + w_prod;
                    r_sum <= r_sum + 48'(r_s);
                end
                ST_UPD: begin
                    r_fill <= w_full_nx ? w_n : r_fill + NW'(1);
                    r_full <= w_full_nx;
                    if ({1'b0, r_slot} + NW'(1) >= w_n) r_slot <= '0;
                    else r_slot <= r_slot + AW'(1);
                    r_d <= 64'($signed({1'b0, w_n}) * r_s) - 64'(r_sum);
                    r_sa <= SIDE_HOLD;
                    r_sb <= SIDE_HOLD;
                end
                ST_DSQ: if (w_done) r_t <= w_prod;
                ST_LHS: if (w_done) r_lhs <= w_prod << 24;
                ST_NQ: if (w_done) r_t <= w_prod;
                ST_SSQ: if (w_done) r_t <= r_t - w_prod;
                ST_RN: if (w_done) r_t <= w_prod;
                ST_BB: if (w_done) r_t <= w_prod;
                ST_RHS: if (w_done) r_t <= w_prod;
                ST_DEC: begin
                    if (r_lhs > r_t && r_d < 0 && r_pos != POS_LONG) begin
                        r_pos <= POS_LONG;  r_sa <= SIDE_BUY;  r_sb <= SIDE_SELL;
                    end else if (r_lhs > r_t && r_d > 0 && r_pos != POS_SHORT) begin
                        r_pos <= POS_SHORT; r_sa <= SIDE_SELL; r_sb <= SIDE_BUY;
                    end else if (r_pos == POS_LONG && r_d > 0) begin
                        r_pos <= POS_FLAT;  r_sa <= SIDE_SELL; r_sb <= SIDE_BUY;
                    end else if (r_pos == POS_SHORT && r_d < 0) begin
                        r_pos <= POS_FLAT;  r_sa <= SIDE_BUY;  r_sb <= SIDE_SELL;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall     = (r_st != ST_IDLE);
    assign o_valid     = (r_st == ST_OUT);
    assign o_side_a    = r_sa;
    assign o_side_b    = r_sb;
    assign o_warmed_up = r_full;

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> (r_st == ST_IDLE)) else $error("no return to idle");
    a_fill_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= NW'(MAX_WINDOW))) else $error("fill count overrun");
    a_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_warmed_up) |-> (o_side_a == SIDE_HOLD && o_side_b == SIDE_HOLD))
        else $error("signal during warm-up");
endmodule
